// File: src/lpip_pkg.sv
`timescale 1ns / 1ps

package lpip_pkg;

   // protocol characters
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   // status codes reported with every result
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NONDIGIT = 3'd1,
      ST_BADTERM  = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_TOOMANY  = 3'd4
   } status_type;

   // one result item
   typedef struct packed {
      logic [7:0] data_out;
      logic       is_payload;
      logic [5:0] element_index;
      logic       element_end;
      logic       instruction_end;
      logic [5:0] argument_count;
      status_type status;
   } result_type;

endpackage

// File: src/lpip_step.sv
`timescale 1ns / 1ps

module lpip_step #(
   parameter int LEN_BITS     = 16,
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  logic [7:0]           item_data,
   output lpip_pkg::result_type result
);

   localparam int CNT_W = $clog2(MAX_ELEMENTS);
   localparam logic [CNT_W-1:0] LAST_INDEX = CNT_W'(MAX_ELEMENTS - 1);

   typedef enum logic [1:0] {
      PH_LEN  = 2'd0,
      PH_PAY  = 2'd1,
      PH_TERM = 2'd2
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [LEN_BITS-1:0]  length_accum_ff, length_accum_in;
   logic [LEN_BITS-1:0]  bytes_left_ff, bytes_left_in;
   logic [CNT_W-1:0]     element_count_ff, element_count_in;
   lpip_pkg::status_type sticky_error_ff, sticky_error_in;

   logic [7:0]          digit_diff;
   logic [LEN_BITS+3:0] len_ext;
   logic [LEN_BITS+3:0] len_next;
   logic                len_overflow;
   logic [LEN_BITS-1:0] left_dec;
   logic [CNT_W+5:0]    count_ext;

   // length times ten plus the new digit, with room to see overflow
   always_comb begin
      digit_diff   = item_data - lpip_pkg::CHAR_ZERO;
      len_ext      = {4'b0000, length_accum_ff};
      len_next     = (len_ext << 3) + (len_ext << 1)
                     + {{LEN_BITS{1'b0}}, digit_diff[3:0]};
      len_overflow = |len_next[LEN_BITS+3:LEN_BITS];
      left_dec     = bytes_left_ff - LEN_BITS'(bytes_left_ff != '0);
      count_ext    = {6'b000000, element_count_ff};
   end

   // decode one byte against the parse state
   always_comb begin
      phase_in         = phase_ff;
      length_accum_in  = length_accum_ff;
      bytes_left_in    = bytes_left_ff;
      element_count_in = element_count_ff;
      sticky_error_in  = sticky_error_ff;

      result.data_out        = item_data;
      result.is_payload      = 1'b0;
      result.element_index   = count_ext[5:0];
      result.element_end     = 1'b0;
      result.instruction_end = 1'b0;
      result.argument_count  = 6'd0;

      if (sticky_error_ff == lpip_pkg::ST_OK) begin
         case (phase_ff)
            PH_PAY: begin
               result.is_payload = 1'b1;
               bytes_left_in     = left_dec;
               if (left_dec == '0) begin
                  phase_in = PH_TERM;
               end
            end
            PH_TERM: begin
               if (item_data == lpip_pkg::CHAR_COMMA) begin
                  if (element_count_ff == LAST_INDEX) begin
                     sticky_error_in = lpip_pkg::ST_TOOMANY;
                  end else begin
                     result.element_end = 1'b1;
                     element_count_in   = element_count_ff + CNT_W'(1);
                     phase_in           = PH_LEN;
                  end
               end else if (item_data == lpip_pkg::CHAR_SEMI) begin
                  result.element_end     = 1'b1;
                  result.instruction_end = 1'b1;
                  result.argument_count  = count_ext[5:0];
                  element_count_in       = '0;
                  phase_in               = PH_LEN;
               end else begin
                  sticky_error_in = lpip_pkg::ST_BADTERM;
               end
            end
            default: begin
               // length field; an unused phase code also lands here
               if (item_data inside {[lpip_pkg::CHAR_ZERO:lpip_pkg::CHAR_NINE]}) begin
                  if (len_overflow) begin
                     sticky_error_in = lpip_pkg::ST_OVERFLOW;
                  end else begin
                     length_accum_in = len_next[LEN_BITS-1:0];
                  end
               end else if (item_data == lpip_pkg::CHAR_DOT) begin
                  bytes_left_in   = length_accum_ff;
                  length_accum_in = '0;
                  phase_in        = (length_accum_ff == '0) ? PH_TERM : PH_PAY;
               end else begin
                  sticky_error_in = lpip_pkg::ST_NONDIGIT;
               end
            end
         endcase
      end

      result.status = sticky_error_in;
   end

   // advance the parse state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_LEN;
         length_accum_ff  <= '0;
         bytes_left_ff    <= '0;
         element_count_ff <= '0;
         sticky_error_ff  <= lpip_pkg::ST_OK;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         length_accum_ff  <= length_accum_in;
         bytes_left_ff    <= bytes_left_in;
         element_count_ff <= element_count_in;
         sticky_error_ff  <= sticky_error_in;
      end
   end

endmodule

// File: src/lpip_skid.sv
`timescale 1ns / 1ps

module lpip_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  lpip_pkg::result_type push_data,
   output logic                 push_ready,
   output logic                 out_valid,
   output lpip_pkg::result_type out_data,
   input  logic                 out_stall
);

   logic                 main_valid_ff;
   logic                 skid_valid_ff;
   lpip_pkg::result_type main_ff;
   lpip_pkg::result_type skid_ff;

   logic drain;
   logic push;

   always_comb begin
      drain      = main_valid_ff && !out_stall;
      push_ready = !skid_valid_ff;
      push       = push_valid && !skid_valid_ff;
      out_valid  = main_valid_ff;
      out_data   = main_ff;
   end

   // track which of the two slots hold a result
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (drain) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !drain) begin
            skid_valid_ff <= 1'b1;
         end else begin
            main_valid_ff <= 1'b1;
         end
      end else if (drain) begin
         main_valid_ff <= 1'b0;
      end
   end

   // move payload: refill the main slot from the skid slot first
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (drain) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !drain) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

endmodule

// File: src/length_prefixed_instruction_parser.sv
`timescale 1ns / 1ps
// Each transferred byte passes through the input register, then its result through the result
// register, from which it is offered; the result is held there while the result side stalls.
// Throughput: one byte per cycle with no result stall; the state update is a single pass.
// A two-entry result buffer registers the input stall, set once a result stall fills the skid.
// Reset (synchronous, active high) empties the pipeline and returns the parser to the
// length phase with no elements counted and no error.

module length_prefixed_instruction_parser #(
   parameter int LEN_BITS     = 16,
   parameter int MAX_ELEMENTS = 64
) (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_in,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_out,
   output logic       rsp_is_payload,
   output logic [5:0] rsp_element_index,
   output logic       rsp_element_end,
   output logic       rsp_instruction_end,
   output logic [5:0] rsp_argument_count,
   output logic [2:0] rsp_status
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_data_ff;

   logic                 req_accept;
   logic                 step_fire;
   logic                 buf_ready;
   lpip_pkg::result_type step_result;
   lpip_pkg::result_type rsp_data;

   // hold the input byte until the result buffer takes its result
   always_comb begin
      step_fire   = in_valid_ff && buf_ready;
      req_stall   = in_valid_ff && !buf_ready;
      req_accept  = req_valid && !req_stall;
      in_valid_in = req_accept ? 1'b1 : (step_fire ? 1'b0 : in_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data_in;
      end
   end

   lpip_step #(
      .LEN_BITS     (LEN_BITS),
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_step (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_fire),
      .item_data (in_data_ff),
      .result    (step_result)
   );

   lpip_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push_valid (in_valid_ff),
      .push_data  (step_result),
      .push_ready (buf_ready),
      .out_valid  (rsp_valid),
      .out_data   (rsp_data),
      .out_stall  (rsp_stall)
   );

   // break the result out onto its ports
   assign rsp_data_out        = rsp_data.data_out;
   assign rsp_is_payload      = rsp_data.is_payload;
   assign rsp_element_index   = rsp_data.element_index;
   assign rsp_element_end     = rsp_data.element_end;
   assign rsp_instruction_end = rsp_data.instruction_end;
   assign rsp_argument_count  = rsp_data.argument_count;
   assign rsp_status          = rsp_data.status;

endmodule

// File: src/lpip_checker.sv
`timescale 1ns / 1ps

module lpip_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_data_in,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_data_out,
   input logic       rsp_is_payload,
   input logic [5:0] rsp_element_index,
   input logic       rsp_element_end,
   input logic       rsp_instruction_end,
   input logic [5:0] rsp_argument_count,
   input logic [2:0] rsp_status
);

   logic       req_xfer;
   logic       rsp_xfer;
   logic [2:0] pending_ff;
   logic       err_seen_ff;
   logic [2:0] err_code_ff;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // count bytes in flight and remember the first reported error
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff  <= 3'd0;
         err_seen_ff <= 1'b0;
         err_code_ff <= 3'd0;
      end else begin
         pending_ff <= pending_ff + 3'(req_xfer) - 3'(rsp_xfer);
         if (rsp_xfer && !err_seen_ff && rsp_status != 3'(lpip_pkg::ST_OK)) begin
            err_seen_ff <= 1'b1;
            err_code_ff <= rsp_status;
         end
      end
   end

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_status) && $stable(rsp_element_index))
      else $error("stalled result changed");

   // no more than three bytes between input and result
   assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("too many bytes in flight");

   // with no result waiting the input side never stalls
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result buffer");

   // an error once reported stays, with all flags clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && err_seen_ff |-> rsp_status == err_code_ff && !rsp_is_payload
         && !rsp_element_end && !rsp_instruction_end && rsp_argument_count == 6'd0)
      else $error("error did not stick");

   // an instruction end closes an element and counts all its arguments
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_instruction_end |-> rsp_element_end
         && rsp_argument_count == rsp_element_index)
      else $error("instruction end inconsistent");

endmodule

bind length_prefixed_instruction_parser lpip_checker u_lpip_checker (.*);
